>>> design/ppls_pkg.sv
// Shared types and constants for the Phong point light shader.
// Used by ppls_power and the top level; depends on nothing.
`timescale 1ns / 1ps

package ppls_pkg;

  // Q2.14 one, Q1.15 one
  localparam int unsigned UNIT_ONE = 16384;
  localparam int unsigned OUT_ONE  = 32768;

  // Latency of one vector normalizer, in register stages
  localparam int UNIT_LAT = 43;

  // Exponent register width and the number of power steps it needs
  localparam int SHINE_W     = 8;
  localparam int SHINE_STEPS = (1 << SHINE_W) - 1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WALL_NORMAL    = 3'd0,
    CFG_MATERIAL_COLOR = 3'd1,
    CFG_AMBIENT_COEFF  = 3'd2,
    CFG_DIFFUSE_COEFF  = 3'd3,
    CFG_SPECULAR_COEFF = 3'd4,
    CFG_SHINE_EXPONENT = 3'd5
  } cfg_idx_e;

  // Input word
  typedef struct packed {
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] light_x;
    logic signed [31:0] light_y;
    logic signed [31:0] light_z;
    logic [15:0]        ambient_red;
    logic [15:0]        ambient_green;
    logic [15:0]        ambient_blue;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } out_word_t;

endpackage

>>> design/ppls_delay.sv
// Enabled shift line that delays a payload by a fixed number of stages.
// Uses no package items.
`timescale 1ns / 1ps

module ppls_delay #(
  parameter int W     = 16,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [DEPTH];

  // shift on every advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

>>> design/ppls_unit.sv
// Pipelined vector normalizer: 3-component signed vector to Q2.14 unit vector.
// Block scaling, bit-per-stage square root, bit-per-stage division.
// Uses no package items; ppls_pkg records its latency as UNIT_LAT.
`timescale 1ns / 1ps

module ppls_unit #(
  parameter int IN_W = 32
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [IN_W-1:0] vec_i  [3],
  output logic signed [15:0]     unit_o [3]
);

  localparam int PW   = $clog2(IN_W);
  localparam int SQ_N = 21;
  localparam int DV_N = 15;

  typedef struct packed {
    logic [2:0][19:0] m;
    logic [2:0]       neg;
    logic             zero;
  } carry_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
  } flag_t;

  // stage 1: magnitudes
  logic [IN_W-1:0] mag_q [3];
  logic [2:0]      neg1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= vec_i[i][IN_W-1];
        mag_q[i]  <= vec_i[i][IN_W-1] ? (~unsigned'(vec_i[i]) + IN_W'(1))
                                      : unsigned'(vec_i[i]);
      end
    end
  end

  // stage 2: leading one of the largest magnitude
  logic [IN_W-1:0] ora;
  logic [PW-1:0]   pos_d, pos_q;
  logic [IN_W-1:0] mag2_q [3];
  logic [2:0]      neg2_q;
  logic            zero2_q;

  always_comb begin
    ora   = mag_q[0] | mag_q[1] | mag_q[2];
    pos_d = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (ora[b]) pos_d = PW'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q   <= pos_d;
      mag2_q  <= mag_q;
      neg2_q  <= neg1_q;
      zero2_q <= (ora == '0);
    end
  end

  // stage 3: scale so the largest lies in [2^19, 2^20)
  carry_t        c3_d, c3_q;
  logic [IN_W-1:0] sh;

  always_comb begin
    c3_d.neg  = neg2_q;
    c3_d.zero = zero2_q;
    sh        = '0;
    for (int i = 0; i < 3; i++) begin
      if (pos_q >= PW'(19)) begin
        sh = mag2_q[i] >> (pos_q - PW'(19));
      end else begin
        sh = mag2_q[i] << (PW'(19) - pos_q);
      end
      c3_d.m[i] = sh[19:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) c3_q <= c3_d;
  end

  // stage 4: squares
  logic [39:0] sq_q [3];
  carry_t      c4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= 40'(c3_q.m[i]) * 40'(c3_q.m[i]);
      end
      c4_q <= c3_q;
    end
  end

  // stage 5: sum of squares, start of square root
  logic [41:0] srem_q [SQ_N+1];
  logic [20:0] sres_q [SQ_N+1];
  carry_t      sc_q   [SQ_N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srem_q[0] <= 42'(sq_q[0]) + 42'(sq_q[1]) + 42'(sq_q[2]);
      sres_q[0] <= '0;
      sc_q[0]   <= c4_q;
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam int B = SQ_N - 1 - j;
    logic [43:0] sub;
    logic [43:0] remx;

    always_comb begin
      sub  = (44'(sres_q[j]) << (B + 1)) | (44'(1) << (2 * B));
      remx = 44'(srem_q[j]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sc_q[j+1] <= sc_q[j];
        if (remx >= sub) begin
          srem_q[j+1] <= 42'(remx - sub);
          sres_q[j+1] <= sres_q[j] | (21'(1) << B);
        end else begin
          srem_q[j+1] <= srem_q[j];
          sres_q[j+1] <= sres_q[j];
        end
      end
    end
  end

  // dividend prep: |c| * 2^14 + len/2
  logic [2:0][34:0] drem_q [DV_N+1];
  logic [2:0][14:0] dq_q   [DV_N+1];
  logic [20:0]      dden_q [DV_N+1];
  flag_t            df_q   [DV_N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= {1'b0, sc_q[SQ_N].m[i], 14'd0} + 35'(sres_q[SQ_N] >> 1);
      end
      dq_q[0]      <= '0;
      dden_q[0]    <= sres_q[SQ_N];
      df_q[0].neg  <= sc_q[SQ_N].neg;
      df_q[0].zero <= sc_q[SQ_N].zero;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DV_N; k++) begin : g_div
    localparam int B = DV_N - 1 - k;
    logic [35:0] cmp;

    assign cmp = 36'(dden_q[k]) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dden_q[k+1] <= dden_q[k];
        df_q[k+1]   <= df_q[k];
        for (int i = 0; i < 3; i++) begin
          if (36'(drem_q[k][i]) >= cmp) begin
            drem_q[k+1][i] <= 35'(36'(drem_q[k][i]) - cmp);
            dq_q[k+1][i]   <= dq_q[k][i] | (15'(1) << B);
          end else begin
            drem_q[k+1][i] <= drem_q[k][i];
            dq_q[k+1][i]   <= dq_q[k][i];
          end
        end
      end
    end
  end

  // sign restore; a zero vector gives zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (df_q[DV_N].zero) begin
          unit_o[i] <= '0;
        end else if (df_q[DV_N].neg[i]) begin
          unit_o[i] <= -$signed({1'b0, dq_q[DV_N][i]});
        end else begin
          unit_o[i] <= $signed({1'b0, dq_q[DV_N][i]});
        end
      end
    end
  end

endmodule

>>> design/ppls_power.sv
// Specular power chain: one rounded Q2.14 multiply per stage, up to 255 steps.
// Depends on ppls_pkg for the step count and the Q2.14 one.
`timescale 1ns / 1ps

module ppls_power (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [14:0]                 c_i,
  input  logic [ppls_pkg::SHINE_W-1:0] shine_i,
  output logic [14:0]                 p_o
);

  localparam int N = ppls_pkg::SHINE_STEPS;

  logic [14:0] p_q [N];
  logic [14:0] c_q [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [14:0] pin;
    logic [14:0] cin;
    logic [28:0] prod;

    if (k == 0) begin : g_first
      assign pin = 15'(ppls_pkg::UNIT_ONE);
      assign cin = c_i;
    end else begin : g_next
      assign pin = p_q[k-1];
      assign cin = c_q[k-1];
    end

    assign prod = 29'(pin) * 29'(cin) + 29'(8192);

    // step k applies only while k is below the exponent
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[k] <= cin;
        p_q[k] <= (ppls_pkg::SHINE_W'(k) < shine_i) ? prod[28:14] : pin;
      end
    end
  end

  assign p_o = p_q[N-1];

endmodule

>>> design/phong_point_light_shader.sv
// Phong point light shader, top level: config registers, dot products,
// reflection, color sum and the pipeline valid chain.
// Depends on ppls_pkg, ppls_unit, ppls_power and ppls_delay.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_word_i) takes one shading
//    point per word: view vector, surface point, light position, ambient.
//  - Output channel (out_valid_o / out_stall_i / out_word_o) gives one
//    shaded color word per input word, in order.
//  - Config port writes a register at each edge with cfg_we_i high; write
//    only while no words are in flight.
//  - The path runs through two 43-stage vector normalizers in series,
//    255 power steps and ten stages of dot products and color math.
//  - Throughput is one word per cycle while the output word is not stalled; every stage advances together.
//  - When the output word is stalled the whole pipeline holds and
//    in_stall_o rises in the same cycle; nothing is lost or repeated.
//  - Reset clears the valid chain and loads the register defaults:
//    normal (0,0,1), color (1,1,1), coefficients 1.0, exponent 1.
`timescale 1ns / 1ps

module phong_point_light_shader (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ppls_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ppls_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [47:0]         cfg_data_i
);

  localparam int U   = ppls_pkg::UNIT_LAT;
  localparam int LAT = 2 * U + 264;
  localparam int C_STAGE = 2 * U + 6;

  // config registers
  logic [47:0] wall_q, color_q;
  logic [15:0] ka_q, kd_q, ks_q;
  logic [ppls_pkg::SHINE_W-1:0] shine_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_q  <= 48'h0000_0000_4000;
      color_q <= 48'h8000_8000_8000;
      ka_q    <= 16'h1000;
      kd_q    <= 16'h1000;
      ks_q    <= 16'h1000;
      shine_q <= ppls_pkg::SHINE_W'(1);
    end else if (cfg_we_i) begin
      case (ppls_pkg::cfg_idx_e'(cfg_idx_i))
        ppls_pkg::CFG_WALL_NORMAL:    wall_q  <= cfg_data_i;
        ppls_pkg::CFG_MATERIAL_COLOR: color_q <= cfg_data_i;
        ppls_pkg::CFG_AMBIENT_COEFF:  ka_q    <= cfg_data_i[15:0];
        ppls_pkg::CFG_DIFFUSE_COEFF:  kd_q    <= cfg_data_i[15:0];
        ppls_pkg::CFG_SPECULAR_COEFF: ks_q    <= cfg_data_i[15:0];
        ppls_pkg::CFG_SHINE_EXPONENT: shine_q <= cfg_data_i[ppls_pkg::SHINE_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] n_w [3];
  logic [15:0]        col_w [3];
  for (genvar i = 0; i < 3; i++) begin : g_cfg
    assign n_w[i]   = $signed(wall_q[47-16*i -: 16]);
    assign col_w[i] = color_q[47-16*i -: 16];
  end

  // global advance: hold everything while the output word is stalled
  logic adv;
  assign in_stall_o = out_valid_o & out_stall_i;
  assign adv        = ~in_stall_o;

  // valid chain
  logic [LAT:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-1:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[LAT];

  // stage 0: input register, light direction
  logic signed [31:0] vr_q [3];
  logic signed [32:0] ld_q [3];
  logic [47:0]        amb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vr_q[0] <= in_word_i.view_x;
      vr_q[1] <= in_word_i.view_y;
      vr_q[2] <= in_word_i.view_z;
      ld_q[0] <= 33'(in_word_i.light_x) - 33'(in_word_i.point_x);
      ld_q[1] <= 33'(in_word_i.light_y) - 33'(in_word_i.point_y);
      ld_q[2] <= 33'(in_word_i.light_z) - 33'(in_word_i.point_z);
      amb_q   <= {in_word_i.ambient_red, in_word_i.ambient_green,
                  in_word_i.ambient_blue};
    end
  end

  // unit view and light vectors
  logic signed [15:0] v_u [3];
  logic signed [15:0] l_u [3];

  ppls_unit #(.IN_W(32)) u_unit_v (
    .clk_i (clk_i), .en_i (adv), .vec_i (vr_q), .unit_o (v_u)
  );

  ppls_unit #(.IN_W(33)) u_unit_l (
    .clk_i (clk_i), .en_i (adv), .vec_i (ld_q), .unit_o (l_u)
  );

  // delayed copies of V (to V.R) and L (to R)
  logic [47:0] v_dly, l_dly;

  ppls_delay #(.W(48), .DEPTH(U + 4)) u_dly_v (
    .clk_i (clk_i), .en_i (adv), .d_i ({v_u[0], v_u[1], v_u[2]}), .q_o (v_dly)
  );

  ppls_delay #(.W(48), .DEPTH(3)) u_dly_l (
    .clk_i (clk_i), .en_i (adv), .d_i ({l_u[0], l_u[1], l_u[2]}), .q_o (l_dly)
  );

  // d1: N.V and N.L products
  logic signed [31:0] pnv_q [3];
  logic signed [31:0] pnl_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pnv_q[i] <= n_w[i] * v_u[i];
        pnl_q[i] <= n_w[i] * l_u[i];
      end
    end
  end

  // d2: flip toward the viewer, rounded N.L
  logic signed [33:0] snv, snl, raw;
  logic [33:0]        rmag;
  logic [19:0]        rnl;
  logic signed [16:0] nf_q [3];
  logic signed [18:0] nl_q;

  always_comb begin
    snv  = 34'(pnv_q[0]) + 34'(pnv_q[1]) + 34'(pnv_q[2]);
    snl  = 34'(pnl_q[0]) + 34'(pnl_q[1]) + 34'(pnl_q[2]);
    raw  = snv[33] ? -snl : snl;
    rmag = raw[33] ? unsigned'(-raw) : unsigned'(raw);
    rnl  = 20'((rmag + 34'(8192)) >> 14);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nf_q[i] <= snv[33] ? -17'(n_w[i]) : 17'(n_w[i]);
      end
      nl_q <= raw[33] ? -$signed(19'(rnl)) : $signed(19'(rnl));
    end
  end

  // d3: 2 * NL * N, clamped N.L
  logic signed [35:0] pr2 [3];
  logic signed [36:0] prod2_q [3];
  logic [14:0]        ndl_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr2[i] = nl_q * nf_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod2_q[i] <= {pr2[i], 1'b0};
      end
      if (nl_q < 0) begin
        ndl_q <= '0;
      end else if (nl_q > 19'sd16384) begin
        ndl_q <= 15'(ppls_pkg::UNIT_ONE);
      end else begin
        ndl_q <= nl_q[14:0];
      end
    end
  end

  // d4: unnormalized reflection vector
  logic [36:0]        pmag [3];
  logic [22:0]        prnd [3];
  logic signed [24:0] rr_d [3];
  logic signed [24:0] rr_q [3];
  logic signed [15:0] l_d3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l_d3[i] = $signed(l_dly[47-16*i -: 16]);
      pmag[i] = prod2_q[i][36] ? unsigned'(-prod2_q[i]) : unsigned'(prod2_q[i]);
      prnd[i] = 23'((pmag[i] + 37'(8192)) >> 14);
      rr_d[i] = (prod2_q[i][36] ? -$signed(25'(prnd[i])) : $signed(25'(prnd[i])))
              - 25'(l_d3[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) rr_q <= rr_d;
  end

  // unit reflection vector
  logic signed [15:0] r_u [3];

  ppls_unit #(.IN_W(25)) u_unit_r (
    .clk_i (clk_i), .en_i (adv), .vec_i (rr_q), .unit_o (r_u)
  );

  // d5: V.R products
  logic signed [31:0] pvr_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pvr_q[i] <= $signed(v_dly[47-16*i -: 16]) * r_u[i];
      end
    end
  end

  // d6: rounded and clamped V.R
  logic signed [33:0] svr;
  logic [33:0]        cr;
  logic [14:0]        c_q;

  always_comb begin
    svr = 34'(pvr_q[0]) + 34'(pvr_q[1]) + 34'(pvr_q[2]);
    cr  = (unsigned'(svr) + 34'(8192)) >> 14;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (svr[33]) begin
        c_q <= '0;
      end else if (cr > 34'(ppls_pkg::UNIT_ONE)) begin
        c_q <= 15'(ppls_pkg::UNIT_ONE);
      end else begin
        c_q <= cr[14:0];
      end
    end
  end

  // specular power
  logic [14:0] p_w;

  ppls_power u_power (
    .clk_i (clk_i), .en_i (adv), .c_i (c_q), .shine_i (shine_q), .p_o (p_w)
  );

  // ambient and clamped N.L brought up to the color stages
  logic [47:0] amb_dly;
  logic [14:0] ndl_dly;

  ppls_delay #(.W(48), .DEPTH(2 * U + 261)) u_dly_amb (
    .clk_i (clk_i), .en_i (adv), .d_i (amb_q), .q_o (amb_dly)
  );

  ppls_delay #(.W(15), .DEPTH(U + 258)) u_dly_ndl (
    .clk_i (clk_i), .en_i (adv), .d_i (ndl_q), .q_o (ndl_dly)
  );

  // c1: coefficient products
  logic [31:0] kaa_q [3];
  logic [30:0] kdn_q, ksp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        kaa_q[i] <= 32'(ka_q) * 32'(amb_dly[47-16*i -: 16]);
      end
      kdn_q <= 31'(kd_q) * 31'(ndl_dly);
      ksp_q <= 31'(ks_q) * 31'(p_w);
    end
  end

  // c2: diffuse and specular times material color; ambient carried along
  logic [31:0] a_q   [3];
  logic [46:0] dif_q [3];
  logic [46:0] spc_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_q[i]   <= kaa_q[i];
        dif_q[i] <= 47'(kdn_q) * 47'(col_w[i]);
        spc_q[i] <= 47'(ksp_q) * 47'(col_w[i]);
      end
    end
  end

  // c3: sum, round to Q1.15, clamp to one
  logic [47:0] csum [3];
  logic [21:0] crnd [3];
  logic [15:0] chan [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = {2'b00, a_q[i], 14'd0} + 48'(dif_q[i]) + 48'(spc_q[i]);
      crnd[i] = 22'((csum[i] + (48'(1) << 25)) >> 26);
      chan[i] = (crnd[i] > 22'(ppls_pkg::OUT_ONE)) ? 16'(ppls_pkg::OUT_ONE)
                                                   : crnd[i][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_o.red_out   <= chan[0];
      out_word_o.green_out <= chan[1];
      out_word_o.blue_out  <= chan[2];
    end
  end

  // checks
  ap_out_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.red_out <= 16'(ppls_pkg::OUT_ONE)) &&
                    (out_word_o.green_out <= 16'(ppls_pkg::OUT_ONE)) &&
                    (out_word_o.blue_out <= 16'(ppls_pkg::OUT_ONE)))
    else $error("output channel above one");

  ap_vr_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[C_STAGE] |-> (c_q <= 15'(ppls_pkg::UNIT_ONE)))
    else $error("clamped V.R above one");

  ap_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("valid chain moved while stalled");

endmodule
